>>> hdl/gpf_pkg.sv
// Shared types and constants of the Goldbach prime-pair finder.
// Used by gpf_div, gpf_dp, gpf_ctrl and goldbach_prime_pair_finder.
// No dependencies.
`default_nettype none

package gpf_pkg;

  // input width and result limits
  localparam int NUM_BITS    = 10;
  localparam int MAX_RESULTS = 64;
  localparam int SMALL_W     = 9;
  localparam int LARGE_W     = 10;

  // derived widths
  localparam int CNT_W     = $clog2(MAX_RESULTS + 1);
  localparam int DIV_CNT_W = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;
  localparam int SQ_W      = 2 * NUM_BITS + 1;

  // controller states, one-hot
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b0_0000_0001,
    ST_CHK_I = 9'b0_0000_0010,
    ST_LOAD  = 9'b0_0000_0100,
    ST_TRY   = 9'b0_0000_1000,
    ST_DIV   = 9'b0_0001_0000,
    ST_PAIR  = 9'b0_0010_0000,
    ST_NEXT  = 9'b0_0100_0000,
    ST_FINAL = 9'b0_1000_0000,
    ST_SPARE = 9'b1_0000_0000
  } gpf_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic start;      // load n, restart the pair search
    logic load_m;     // pick the candidate and reset the trial divisor
    logic sel_large;  // candidate is n - i instead of i
    logic start_div;  // launch the remainder unit
    logic step_d;     // move to the next trial divisor
    logic store_pair; // keep the current pair as pending
    logic emit_pend;  // send the pending pair, not last
    logic emit_final; // send the closing beat
    logic inc_i;      // next small candidate
  } gpf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_range;   // i <= n/2
    logic sq_over;    // d*d > m, no divisor left
    logic div_done;   // remainder ready
    logic rem_zero;   // d divides m
    logic out_free;   // output register can take a beat
    logic pend_valid; // a pair is pending
    logic count_last; // next stored pair reaches the limit
  } gpf_status_t;

endpackage

`default_nettype wire

>>> hdl/gpf_div.sv
// Iterative remainder unit: one restoring step per cycle, NUM_BITS steps.
// Depends on gpf_pkg.
`default_nettype none

module gpf_div (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  input  wire  [gpf_pkg::NUM_BITS-1:0]  dividend_i,
  input  wire  [gpf_pkg::NUM_BITS-1:0]  divisor_i,
  output logic                          done_o,
  output logic [gpf_pkg::NUM_BITS-1:0]  rem_o
);
  import gpf_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_BITS-1:0]  rem_q, rem_d;
  logic [NUM_BITS-1:0]  quo_q, quo_d;
  logic [NUM_BITS-1:0]  dvs_q, dvs_d;
  logic [NUM_BITS:0]    shifted;
  logic [NUM_BITS:0]    diff;

  // one restoring step
  assign shifted = {rem_q, quo_q[NUM_BITS-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  // step sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(NUM_BITS - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = diff[NUM_BITS] ? shifted[NUM_BITS-1:0] : diff[NUM_BITS-1:0];
      quo_d = quo_q << 1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

>>> hdl/gpf_dp.sv
// Datapath: search registers, trial divisor, pending pair and output register.
// Depends on gpf_pkg and gpf_div.
`default_nettype none

module gpf_dp (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  gpf_pkg::gpf_cmd_t            cmd_i,
  output gpf_pkg::gpf_status_t         status_o,
  input  wire  [gpf_pkg::NUM_BITS-1:0] number_i,
  input  wire                          out_stall_i,
  output logic                         out_valid_o,
  output logic                         found_o,
  output logic [gpf_pkg::SMALL_W-1:0]  small_prime_o,
  output logic [gpf_pkg::LARGE_W-1:0]  large_prime_o,
  output logic                         last_o
);
  import gpf_pkg::*;

  logic [NUM_BITS-1:0] n_q, i_q, m_q, d_q;
  logic [SQ_W-1:0]     dsq_q;
  logic [NUM_BITS-1:0] rem;
  logic                div_done;
  logic [CNT_W-1:0]    count_q;
  logic                pend_v_q;
  logic [SMALL_W-1:0]  pend_small_q;
  logic [LARGE_W-1:0]  pend_large_q;
  logic                out_valid_q;
  logic                found_q, last_q;
  logic [SMALL_W-1:0]  small_q;
  logic [LARGE_W-1:0]  large_q;
  logic                out_free;
  logic [NUM_BITS-1:0] n_minus_i;

  assign n_minus_i = n_q - i_q;
  assign out_free  = !out_valid_q || !out_stall_i;

  // remainder unit
  gpf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (m_q),
    .divisor_i  (d_q),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  // status back to the controller
  always_comb begin
    status_o.in_range   = i_q <= (n_q >> 1);
    status_o.sq_over    = dsq_q > SQ_W'(m_q);
    status_o.div_done   = div_done;
    status_o.rem_zero   = rem == '0;
    status_o.out_free   = out_free;
    status_o.pend_valid = pend_v_q;
    status_o.count_last = count_q == CNT_W'(MAX_RESULTS - 1);
  end

  // search and candidate registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      n_q <= number_i;
      i_q <= NUM_BITS'(2);
    end else if (cmd_i.inc_i) begin
      i_q <= i_q + 1'b1;
    end
    if (cmd_i.load_m) begin
      m_q   <= cmd_i.sel_large ? n_minus_i : i_q;
      d_q   <= NUM_BITS'(2);
      dsq_q <= SQ_W'(4);
    end else if (cmd_i.step_d) begin
      d_q   <= d_q + 1'b1;
      dsq_q <= dsq_q + SQ_W'({d_q, 1'b1});
    end
    if (cmd_i.store_pair) begin
      pend_small_q <= SMALL_W'(i_q);
      pend_large_q <= LARGE_W'(n_minus_i);
    end
  end

  // pair bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      count_q  <= '0;
    end else if (cmd_i.start) begin
      pend_v_q <= 1'b0;
      count_q  <= '0;
    end else if (cmd_i.store_pair) begin
      pend_v_q <= 1'b1;
      count_q  <= count_q + 1'b1;
    end
  end

  // output beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_pend || cmd_i.emit_final) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pend) begin
      found_q <= 1'b1;
      small_q <= pend_small_q;
      large_q <= pend_large_q;
      last_q  <= 1'b0;
    end else if (cmd_i.emit_final) begin
      found_q <= pend_v_q;
      small_q <= pend_v_q ? pend_small_q : '0;
      large_q <= pend_v_q ? pend_large_q : '0;
      last_q  <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign small_prime_o = small_q;
  assign large_prime_o = large_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

>>> hdl/gpf_ctrl.sv
// Controller: sequences the pair search and the trial-division tests.
// Depends on gpf_pkg.
`default_nettype none

module gpf_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  gpf_pkg::gpf_status_t  status_i,
  output gpf_pkg::gpf_cmd_t     cmd_o
);
  import gpf_pkg::*;

  gpf_state_e state_q, state_d;
  logic       phase_q, phase_d;   // 0 tests i, 1 tests n - i

  assign in_stall_o = state_q != ST_IDLE;

  // next state and commands
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_CHK_I;
        end
      end
      ST_CHK_I: begin
        phase_d = 1'b0;
        state_d = status_i.in_range ? ST_LOAD : ST_FINAL;
      end
      ST_LOAD: begin
        cmd_o.load_m    = 1'b1;
        cmd_o.sel_large = phase_q;
        state_d         = ST_TRY;
      end
      ST_TRY: begin
        // no divisor up to the square root: candidate is prime
        if (status_i.sq_over) begin
          if (!phase_q) begin
            phase_d = 1'b1;
            state_d = ST_LOAD;
          end else begin
            state_d = ST_PAIR;
          end
        end else begin
          cmd_o.start_div = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          if (status_i.rem_zero) begin
            state_d = ST_NEXT;
          end else begin
            cmd_o.step_d = 1'b1;
            state_d      = ST_TRY;
          end
        end
      end
      ST_PAIR: begin
        // previous pair goes out as the new one becomes pending
        if (!status_i.pend_valid || status_i.out_free) begin
          cmd_o.emit_pend  = status_i.pend_valid;
          cmd_o.store_pair = 1'b1;
          state_d          = status_i.count_last ? ST_FINAL : ST_NEXT;
        end
      end
      ST_NEXT: begin
        cmd_o.inc_i = 1'b1;
        state_d     = ST_CHK_I;
      end
      ST_FINAL: begin
        if (status_i.out_free) begin
          cmd_o.emit_final = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/goldbach_prime_pair_finder.sv
// Goldbach prime-pair finder: every prime pair (i, n-i) with 2 <= i <= n/2, up to 64.
// Top level; depends on gpf_pkg, gpf_ctrl and gpf_dp.
//
// Usage:
//   Input channel: number_i with in_valid_i / in_stall_o. One beat is taken
//   only while the block is idle; in_stall_o stays high until the closing
//   result beat of the current number has been loaded into the output register.
//   Output channel: found_o, small_prime_o, large_prime_o, last_o with
//   out_valid_o / out_stall_i. Pairs come out in order of rising i; last_o
//   marks the final beat. With no pair, one beat with found_o low and
//   zero primes is sent, last_o high. At most 64 pairs are reported.
//   Search: each trial divisor runs through the shared remainder unit;
//   divisors from 2 up to floor(sqrt(m)) are tried per candidate m until
//   one divides m. Each candidate i is range-checked and loaded; a prime i
//   is followed by a load of n - i, and each prime pair is stored. The time
//   per number depends on n; numbers are handled one at a time.
//   Receiver stall: the output register holds its beat; the search pauses
//   when a further pair is ready and the register is still full.
//   Reset: asynchronous, active low; the block returns to idle with no
//   beat pending.
`default_nettype none

module goldbach_prime_pair_finder (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [gpf_pkg::NUM_BITS-1:0] number_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         found_o,
  output logic [gpf_pkg::SMALL_W-1:0]  small_prime_o,
  output logic [gpf_pkg::LARGE_W-1:0]  large_prime_o,
  output logic                         last_o
);
  import gpf_pkg::*;

  gpf_cmd_t    cmd;
  gpf_status_t status;

  // sequencer
  gpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  gpf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .number_i      (number_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .found_o       (found_o),
    .small_prime_o (small_prime_o),
    .large_prime_o (large_prime_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire
